### rtl/core/mprm_pkg.sv
// Pulse rate meter package: widths, reset values, register codes, config struct.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package mprm_pkg;

	localparam int CHANNELS    = 6;
	localparam int TIME_BITS   = 16;
	localparam int CH_BITS     = 3;
	localparam int TS_BITS     = 16;
	localparam int RATE_BITS   = 16;
	localparam int WRAP_BITS   = 16;
	localparam int NUM_BITS    = 16;
	localparam int TICK_BITS   = 8;
	localparam int PROD_BITS   = TIME_BITS + TICK_BITS;
	localparam int CNT_BITS    = $clog2(RATE_BITS);
	localparam int CH_IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int EQUAL_GAP   = 10;

	localparam int ADDR_BITS   = 4;
	localparam int DATA_BITS   = 32;

	localparam logic [WRAP_BITS-1:0] WRAP_RESET = WRAP_BITS'(10000);
	localparam logic [NUM_BITS-1:0]  NUM_RESET  = NUM_BITS'(60000);
	localparam logic [TICK_BITS-1:0] TICK_RESET = TICK_BITS'(10);

	typedef enum logic [1:0] {
		REG_WRAP_TICKS     = 2'd0,
		REG_RATE_NUMERATOR = 2'd1,
		REG_TICK_LENGTH    = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [WRAP_BITS-1:0] wrap_ticks;
		logic [NUM_BITS-1:0]  rate_numerator;
		logic [TICK_BITS-1:0] tick_length;
	} mprm_cfg_t;

endpackage

### rtl/core/mprm_if.sv
// Valid/ready stream interfaces for the edge beats in and the rate beats out.
// Depends on mprm_pkg.
`timescale 1ns / 1ps

interface mprm_in_if;
	import mprm_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CH_BITS-1:0]   channel;
	logic [TS_BITS-1:0]   timestamp;

	modport source (output valid, output channel, output timestamp, input ready);
	modport sink (input valid, input channel, input timestamp, output ready);
endinterface

interface mprm_out_if;
	import mprm_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CH_BITS-1:0]   out_channel;
	logic [RATE_BITS-1:0] rate;
	logic                 updated;

	modport source (output valid, output out_channel, output rate, output updated, input ready);
	modport sink (input valid, input out_channel, input rate, input updated, output ready);
endinterface

### rtl/core/mprm_cfg.sv
// APB register block: wrap_ticks, rate_numerator, tick_length.
// Depends on mprm_pkg.
`timescale 1ns / 1ps

module mprm_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mprm_pkg::ADDR_BITS-1:0] paddr,
	input  logic [mprm_pkg::DATA_BITS-1:0] pwdata,
	output logic [mprm_pkg::DATA_BITS-1:0] prdata,
	output logic                           pready,
	output mprm_pkg::mprm_cfg_t            cfg
);
	import mprm_pkg::*;

	mprm_cfg_t cfg_q;
	reg_idx_t  idx;
	logic      wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wrap_ticks     <= WRAP_RESET;
			cfg_q.rate_numerator <= NUM_RESET;
			cfg_q.tick_length    <= TICK_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_WRAP_TICKS:     cfg_q.wrap_ticks     <= pwdata[WRAP_BITS-1:0];
				REG_RATE_NUMERATOR: cfg_q.rate_numerator <= pwdata[NUM_BITS-1:0];
				REG_TICK_LENGTH:    cfg_q.tick_length    <= pwdata[TICK_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_WRAP_TICKS:     prdata = DATA_BITS'(cfg_q.wrap_ticks);
			REG_RATE_NUMERATOR: prdata = DATA_BITS'(cfg_q.rate_numerator);
			REG_TICK_LENGTH:    prdata = DATA_BITS'(cfg_q.tick_length);
			default:            prdata = '0;
		endcase
	end

endmodule

### rtl/core/mprm_muldiv.sv
// Serial arithmetic: shift-add multiply of gap by tick length, one multiplier bit
// per cycle, then restoring divide of the numerator, one quotient bit per cycle.
// Depends on mprm_pkg.
`timescale 1ns / 1ps

module mprm_muldiv (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [mprm_pkg::TIME_BITS-1:0] gap,
	input  logic [mprm_pkg::TICK_BITS-1:0] tick_length,
	input  logic [mprm_pkg::NUM_BITS-1:0]  numerator,
	output logic                           done,
	output logic [mprm_pkg::RATE_BITS-1:0] quotient
);
	import mprm_pkg::*;

	typedef enum logic [2:0] {
		MD_IDLE = 3'b001,
		MD_MUL  = 3'b010,
		MD_DIV  = 3'b100
	} md_state_t;

	md_state_t              state_q;
	logic [CNT_BITS-1:0]    cnt_q;
	logic [PROD_BITS-1:0]   mcand_q;
	logic [TICK_BITS-1:0]   mplier_q;
	logic [PROD_BITS-1:0]   prod_q;
	logic [PROD_BITS-1:0]   rem_q;
	logic [RATE_BITS-1:0]   quo_q;
	logic                   done_q;

	logic [PROD_BITS:0]     trial;
	logic                   fits;
	logic [PROD_BITS:0]     diff;

	assign trial = {rem_q, quo_q[RATE_BITS-1]};
	assign fits  = trial >= {1'b0, prod_q};
	assign diff  = trial - {1'b0, prod_q};

	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= MD_IDLE;
			cnt_q    <= '0;
			mcand_q  <= '0;
			mplier_q <= '0;
			prod_q   <= '0;
			rem_q    <= '0;
			quo_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= (state_q == MD_DIV) && ((prod_q == '0) || (cnt_q == '0));
			case (state_q)
				MD_IDLE: begin
					if (start) begin
						mcand_q  <= PROD_BITS'(gap);
						mplier_q <= tick_length;
						prod_q   <= '0;
						cnt_q    <= CNT_BITS'(TICK_BITS - 1);
						state_q  <= MD_MUL;
					end
				end
				MD_MUL: begin
					if (mplier_q[0]) begin
						prod_q <= prod_q + mcand_q;
					end
					mcand_q  <= {mcand_q[PROD_BITS-2:0], 1'b0};
					mplier_q <= {1'b0, mplier_q[TICK_BITS-1:1]};
					if (cnt_q == '0) begin
						rem_q   <= '0;
						quo_q   <= RATE_BITS'(numerator);
						cnt_q   <= CNT_BITS'(RATE_BITS - 1);
						state_q <= MD_DIV;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				MD_DIV: begin
					if (prod_q == '0) begin
						// zero divisor saturates
						quo_q   <= '1;
						state_q <= MD_IDLE;
					end else begin
						rem_q <= fits ? diff[PROD_BITS-1:0] : trial[PROD_BITS-1:0];
						quo_q <= {quo_q[RATE_BITS-2:0], fits};
						if (cnt_q == '0) begin
							state_q <= MD_IDLE;
						end else begin
							cnt_q <= cnt_q - 1'b1;
						end
					end
				end
				default: state_q <= MD_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/multichannel_pulse_rate_meter_core.sv
// Top level of the multichannel pulse rate meter: per-channel state and sequencer.
// Depends on mprm_pkg, mprm_if, mprm_cfg, mprm_muldiv.
//
// Usage:
//   req carries one beat per falling edge: channel and tick timestamp.
//   rsp returns one beat per edge: out_channel, rate and updated.
//   APB port sets wrap_ticks (0x0), rate_numerator (0x4), tick_length (0x8);
//   write only while idle.
// Sequencing:
//   One edge in flight at a time; req.ready is high only when the sequencer is idle.
//   First edge on a channel, or an out-of-range channel: no arithmetic; the
//   result passes ST_OUT into the rsp output register, then the sequencer is idle.
//   Armed channel: a serial multiply, then a serial divide in the arithmetic
//   unit (ST_CALC), then ST_OUT and the rsp output register. A zero divisor
//   ends the divide at once.
// Reset:
//   All channels disarmed, stored times and rates zero, registers at defaults.
// Backpressure:
//   The rsp output register holds its beat until taken; a following edge is
//   still accepted and computed, and waits for the output register to free.
`timescale 1ns / 1ps

module multichannel_pulse_rate_meter_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mprm_pkg::ADDR_BITS-1:0] paddr,
	input  logic [mprm_pkg::DATA_BITS-1:0] pwdata,
	output logic [mprm_pkg::DATA_BITS-1:0] prdata,
	output logic                           pready,
	mprm_in_if.sink                        req,
	mprm_out_if.source                     rsp
);
	import mprm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CALC = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	mprm_cfg_t              cfg;
	state_t                 state_q;

	logic                   armed_q     [CHANNELS];
	logic [TIME_BITS-1:0]   last_time_q [CHANNELS];
	logic [RATE_BITS-1:0]   rate_q      [CHANNELS];

	logic [CH_BITS-1:0]     ch_q;
	logic [RATE_BITS-1:0]   res_rate_q;
	logic                   res_upd_q;
	logic                   rsp_valid_q;
	logic [CH_BITS-1:0]     rsp_ch_q;
	logic [RATE_BITS-1:0]   rsp_rate_q;
	logic                   rsp_upd_q;

	logic                   accept;
	logic                   in_range;
	logic [CH_IDX_BITS-1:0] idx;
	logic [CH_IDX_BITS-1:0] idx_q;
	logic [TIME_BITS-1:0]   t_in;
	logic [TIME_BITS-1:0]   t_last;
	logic [TIME_BITS-1:0]   gap;
	logic                   md_start;
	logic                   md_done;
	logic [RATE_BITS-1:0]   md_quo;

	mprm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign accept   = req.valid && req.ready;
	assign in_range = {1'b0, req.channel} < (CH_BITS + 1)'(CHANNELS);
	assign idx      = CH_IDX_BITS'(req.channel);
	assign idx_q    = CH_IDX_BITS'(ch_q);
	assign t_in     = TIME_BITS'(req.timestamp);
	assign t_last   = in_range ? last_time_q[idx] : '0;

	always_comb begin
		if (t_in == t_last) begin
			gap = TIME_BITS'(EQUAL_GAP);
		end else if (t_in > t_last) begin
			gap = t_in - t_last;
		end else begin
			gap = TIME_BITS'(cfg.wrap_ticks) - t_last + t_in;
		end
	end

	assign md_start = accept && in_range && armed_q[idx];

	mprm_muldiv u_md (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (md_start),
		.gap         (gap),
		.tick_length (cfg.tick_length),
		.numerator   (cfg.rate_numerator),
		.done        (md_done),
		.quotient    (md_quo)
	);

	assign req.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.out_channel = rsp_ch_q;
	assign rsp.rate        = rsp_rate_q;
	assign rsp.updated     = rsp_upd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			for (int k = 0; k < CHANNELS; k++) begin
				armed_q[k]     <= 1'b0;
				last_time_q[k] <= '0;
				rate_q[k]      <= '0;
			end
			ch_q        <= '0;
			res_rate_q  <= '0;
			res_upd_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_ch_q    <= '0;
			rsp_rate_q  <= '0;
			rsp_upd_q   <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ch_q <= req.channel;
						if (in_range) begin
							armed_q[idx]     <= 1'b1;
							last_time_q[idx] <= t_in;
							if (armed_q[idx]) begin
								state_q <= ST_CALC;
							end else begin
								res_rate_q <= rate_q[idx];
								res_upd_q  <= 1'b0;
								state_q    <= ST_OUT;
							end
						end else begin
							res_rate_q <= '0;
							res_upd_q  <= 1'b0;
							state_q    <= ST_OUT;
						end
					end
				end
				ST_CALC: begin
					if (md_done) begin
						rate_q[idx_q] <= md_quo;
						res_rate_q    <= md_quo;
						res_upd_q     <= 1'b1;
						state_q       <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_ch_q    <= ch_q;
						rsp_rate_q  <= res_rate_q;
						rsp_upd_q   <= res_upd_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/mprm_checker.sv
// Port-level checks for the pulse rate meter, bound to the top level.
// Depends on mprm_pkg and multichannel_pulse_rate_meter_core.
`timescale 1ns / 1ps

module mprm_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [mprm_pkg::CH_BITS-1:0]   rsp_out_channel,
	input logic [mprm_pkg::RATE_BITS-1:0] rsp_rate,
	input logic                           rsp_updated
);
	import mprm_pkg::*;

	// one edge in flight: no back-to-back acceptance
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("edge accepted while previous edge still in flight");

	// unknown channel gives an empty result
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_out_channel >= CHANNELS) |-> (rsp_rate == '0) && !rsp_updated)
		else $error("out-of-range channel returned a rate");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result beat dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_rate) && $stable(rsp_out_channel))
		else $error("result beat changed while stalled");

endmodule

bind multichannel_pulse_rate_meter_core mprm_checker u_mprm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_out_channel (rsp.out_channel),
	.rsp_rate        (rsp.rate),
	.rsp_updated     (rsp.updated)
);
